[rtl/core/sis_pkg.sv]
// ----------------------------------------------------------------------------
// sis_pkg
// shared widths, operation and status codes, and the xorshift step for the
// sparse integer set
// ----------------------------------------------------------------------------
package sis_pkg;

  localparam int SIS_CAP     = 256;
  localparam int SIS_VAL_W   = 8;
  localparam int SIS_CNT_W   = 9;
  localparam int SIS_FUNC_W  = 3;
  localparam int SIS_RNG_W   = 32;
  localparam int SIS_DATA_W  = 24;
  localparam int SIS_STEP_W  = 5;

  localparam logic [SIS_RNG_W-1:0] SIS_RNG_SEED = 32'd1234567;
  localparam int SIS_SH_A = 13;
  localparam int SIS_SH_B = 17;
  localparam int SIS_SH_C = 5;

  typedef enum logic [SIS_FUNC_W-1:0] {
    FN_INSERT   = 3'd0,
    FN_REMOVE   = 3'd1,
    FN_CONTAINS = 3'd2,
    FN_PICK     = 3'd3,
    FN_EXTRACT  = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_PRESENT = 2'd1,
    ST_ABSENT  = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  function automatic logic [SIS_RNG_W-1:0] sis_rng_next(input logic [SIS_RNG_W-1:0] x);
    logic [SIS_RNG_W-1:0] a;
    logic [SIS_RNG_W-1:0] b;
    a = x ^ (x << SIS_SH_A);
    b = a ^ (a >> SIS_SH_B);
    return b ^ (b << SIS_SH_C);
  endfunction

endpackage

[rtl/core/sis_ram.sv]
// ----------------------------------------------------------------------------
// sis_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module sis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/core/sis_divmod.sv]
// ----------------------------------------------------------------------------
// sis_divmod
// restoring remainder unit: 32-bit dividend by 9-bit divisor, one bit a cycle
// ----------------------------------------------------------------------------
module sis_divmod (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [sis_pkg::SIS_RNG_W-1:0]  dividend,
  input  logic [sis_pkg::SIS_CNT_W-1:0]  divisor,
  output logic                           done,
  output logic [sis_pkg::SIS_VAL_W-1:0]  rem
);
  import sis_pkg::*;

  logic                  active_r, active_nxt;
  logic                  done_r, done_nxt;
  logic [SIS_STEP_W-1:0] step_r, step_nxt;
  logic [SIS_RNG_W-1:0]  dvd_r, dvd_nxt;
  logic [SIS_CNT_W-1:0]  dsr_r, dsr_nxt;
  logic [SIS_CNT_W-1:0]  rem_r, rem_nxt;
  logic [SIS_CNT_W:0]    trial;

  always_comb begin
    active_nxt = active_r;
    done_nxt   = 1'b0;
    step_nxt   = step_r;
    dvd_nxt    = dvd_r;
    dsr_nxt    = dsr_r;
    rem_nxt    = rem_r;
    trial      = {rem_r, dvd_r[SIS_RNG_W-1]};
    if (start) begin
      active_nxt = 1'b1;
      step_nxt   = SIS_STEP_W'(SIS_RNG_W - 1);
      dvd_nxt    = dividend;
      dsr_nxt    = divisor;
      rem_nxt    = '0;
    end else if (active_r) begin
      dvd_nxt = dvd_r << 1;
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = SIS_CNT_W'(trial - {1'b0, dsr_r});
      end else begin
        rem_nxt = trial[SIS_CNT_W-1:0];
      end
      step_nxt = step_r - 1'b1;
      if (step_r == '0) begin
        active_nxt = 1'b0;
        done_nxt   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
      step_r   <= '0;
    end else begin
      active_r <= active_nxt;
      done_r   <= done_nxt;
      step_r   <= step_nxt;
    end
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r[SIS_VAL_W-1:0];

endmodule

[rtl/core/sparse_integer_set.sv]
// ----------------------------------------------------------------------------
// sparse_integer_set
// set of 8-bit integers kept as a dense member list plus a position table
// ----------------------------------------------------------------------------
// flow: insert, contains and no-op codes go straight to emit; remove adds a
// fill step (S_RMV); random pick waits on the 32-step serial remainder unit
// (S_DIV), then reads the member (S_PICK); random extract adds S_EXT; one item
// at a time, next item taken on return to idle
// reset: synchronous, clears valid bits, count 0, rng seed 1234567
// ----------------------------------------------------------------------------
module sparse_integer_set (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [sis_pkg::SIS_VAL_W-1:0]   in_tdata,   // [7:0] value
  input  logic [sis_pkg::SIS_FUNC_W-1:0]  in_tuser,   // [2:0] func
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [sis_pkg::SIS_DATA_W-1:0]  out_tdata,  // [0] found, [8:1] picked, [17:9] count
  output logic [1:0]                      out_tuser   // [1:0] status
);
  import sis_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_RMV, S_DIV, S_PICK, S_EXT, S_EMIT
  } state_t;

  state_t                state_r, state_nxt;
  logic [SIS_CNT_W-1:0]  count_r, count_nxt;
  logic [SIS_RNG_W-1:0]  rng_r, rng_nxt;
  logic [SIS_CAP-1:0]    valid_r, valid_nxt;
  logic [SIS_VAL_W-1:0]  value_r, value_nxt;
  func_t                 func_r, func_nxt;
  logic [SIS_VAL_W-1:0]  idx_r, idx_nxt;
  logic [SIS_VAL_W-1:0]  picked_r, picked_nxt;
  logic                  found_r, found_nxt;
  status_t               status_r, status_nxt;
  logic                  out_tvalid_r, out_tvalid_nxt;
  logic                  out_found_r, out_found_nxt;
  logic [SIS_VAL_W-1:0]  out_picked_r, out_picked_nxt;
  logic [SIS_CNT_W-1:0]  out_count_r, out_count_nxt;
  status_t               out_status_r, out_status_nxt;

  logic                  mem_we;
  logic [SIS_VAL_W-1:0]  mem_waddr, mem_wdata, mem_raddr, mem_rdata;
  logic                  pos_we;
  logic [SIS_VAL_W-1:0]  pos_waddr, pos_wdata, pos_raddr, pos_rdata;
  logic                  div_start, div_done;
  logic [SIS_VAL_W-1:0]  div_rem;
  logic [SIS_RNG_W-1:0]  rng_step;
  logic [SIS_VAL_W-1:0]  in_value;
  func_t                 in_func;
  logic [SIS_VAL_W-1:0]  last_idx;

  assign in_value  = in_tdata;
  assign in_func   = func_t'(in_tuser);
  assign rng_step  = sis_rng_next(rng_r);
  assign last_idx  = count_r[SIS_VAL_W-1:0] - 1'b1;
  assign in_tready = (state_r == S_IDLE);

  sis_ram #(.WIDTH(SIS_VAL_W), .DEPTH(SIS_CAP)) u_members (
    .clk     (clk),
    .we      (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  sis_ram #(.WIDTH(SIS_VAL_W), .DEPTH(SIS_CAP)) u_positions (
    .clk     (clk),
    .we      (pos_we),
    .wr_addr (pos_waddr),
    .wr_data (pos_wdata),
    .rd_addr (pos_raddr),
    .rd_data (pos_rdata)
  );

  sis_divmod u_divmod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rng_step),
    .divisor  (count_r),
    .done     (div_done),
    .rem      (div_rem)
  );

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    rng_nxt        = rng_r;
    valid_nxt      = valid_r;
    value_nxt      = value_r;
    func_nxt       = func_r;
    idx_nxt        = idx_r;
    picked_nxt     = picked_r;
    found_nxt      = found_r;
    status_nxt     = status_r;
    out_tvalid_nxt = out_tvalid_r & ~out_tready;
    out_found_nxt  = out_found_r;
    out_picked_nxt = out_picked_r;
    out_count_nxt  = out_count_r;
    out_status_nxt = out_status_r;
    mem_we         = 1'b0;
    mem_waddr      = idx_r;
    mem_wdata      = mem_rdata;
    mem_raddr      = idx_r;
    pos_we         = 1'b0;
    pos_waddr      = mem_rdata;
    pos_wdata      = idx_r;
    pos_raddr      = value_r;
    div_start      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          value_nxt  = in_value;
          func_nxt   = in_func;
          found_nxt  = 1'b0;
          picked_nxt = '0;
          status_nxt = ST_OK;
          state_nxt  = S_EMIT;
          unique case (in_func)
            FN_INSERT: begin
              if (valid_r[in_value]) begin
                status_nxt = ST_PRESENT;
              end else begin
                mem_we              = 1'b1;
                mem_waddr           = count_r[SIS_VAL_W-1:0];
                mem_wdata           = in_value;
                pos_we              = 1'b1;
                pos_waddr           = in_value;
                pos_wdata           = count_r[SIS_VAL_W-1:0];
                valid_nxt[in_value] = 1'b1;
                count_nxt           = count_r + 1'b1;
              end
            end
            FN_REMOVE: begin
              if (!valid_r[in_value]) begin
                status_nxt = ST_ABSENT;
              end else begin
                pos_raddr = in_value;
                mem_raddr = last_idx;
                state_nxt = S_RMV;
              end
            end
            FN_CONTAINS: begin
              found_nxt = valid_r[in_value];
            end
            FN_PICK, FN_EXTRACT: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                rng_nxt   = rng_step;
                div_start = 1'b1;
                state_nxt = S_DIV;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_RMV: begin
        // fill the hole with the last member
        mem_we             = 1'b1;
        mem_waddr          = pos_rdata;
        mem_wdata          = mem_rdata;
        pos_we             = 1'b1;
        pos_waddr          = mem_rdata;
        pos_wdata          = pos_rdata;
        valid_nxt[value_r] = 1'b0;
        count_nxt          = count_r - 1'b1;
        state_nxt          = S_EMIT;
      end
      S_DIV: begin
        mem_raddr = div_rem;
        if (div_done) begin
          idx_nxt   = div_rem;
          state_nxt = S_PICK;
        end
      end
      S_PICK: begin
        picked_nxt = mem_rdata;
        if (func_r == FN_EXTRACT) begin
          mem_raddr = last_idx;
          state_nxt = S_EXT;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EXT: begin
        mem_we              = 1'b1;
        mem_waddr           = idx_r;
        mem_wdata           = mem_rdata;
        pos_we              = 1'b1;
        pos_waddr           = mem_rdata;
        pos_wdata           = idx_r;
        valid_nxt[picked_r] = 1'b0;
        count_nxt           = count_r - 1'b1;
        state_nxt           = S_EMIT;
      end
      S_EMIT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_found_nxt  = found_r;
          out_picked_nxt = picked_r;
          out_count_nxt  = count_r;
          out_status_nxt = status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      rng_r        <= SIS_RNG_SEED;
      valid_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      rng_r        <= rng_nxt;
      valid_r      <= valid_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    value_r      <= value_nxt;
    func_r       <= func_nxt;
    idx_r        <= idx_nxt;
    picked_r     <= picked_nxt;
    found_r      <= found_nxt;
    status_r     <= status_nxt;
    out_found_r  <= out_found_nxt;
    out_picked_r <= out_picked_nxt;
    out_count_r  <= out_count_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(SIS_DATA_W - SIS_CNT_W - SIS_VAL_W - 1){1'b0}},
                       out_count_r, out_picked_r, out_found_r};
  assign out_tuser  = out_status_r;

endmodule

[rtl/core/sis_checker.sv]
// ----------------------------------------------------------------------------
// sis_checker
// port-level checks on the sparse integer set, bound to the top level
// ----------------------------------------------------------------------------
module sis_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [sis_pkg::SIS_DATA_W-1:0]  out_tdata,
  input logic [1:0]                      out_tuser
);
  import sis_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while busy");

  // count never beyond capacity
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[17:9] <= 9'd256)
    else $error("count above capacity");

  // empty status means nothing picked and no members
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_EMPTY |-> out_tdata[17:1] == 17'd0)
    else $error("empty status with members or pick");

  // no result right after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind sparse_integer_set sis_checker u_sis_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
